>>> sv/utrbd_pkg.sv
// Shared types and constants for the USB transmit ring block drainer.
// No dependencies; used by utrbd_step and usb_tx_ring_block_drainer_core.
package utrbd_pkg;

    localparam int RING_DEPTH_DEF  = 1024;
    localparam int BLOCK_LIMIT_DEF = 64;
    localparam int USB_PACKET      = 64;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef struct packed {
        logic       write_accepted;
        logic       send_valid;
        logic       send_zero_length;
        logic [9:0] send_start;
        logic [6:0] send_length;
        logic       read_en;
    } result_t;

endpackage

>>> sv/utrbd_step.sv
// Per-request next-state and result logic of the transmit ring.
// Depends on utrbd_pkg.
module utrbd_step #(
    parameter int RING_DEPTH  = utrbd_pkg::RING_DEPTH_DEF,
    parameter int BLOCK_LIMIT = utrbd_pkg::BLOCK_LIMIT_DEF,
    localparam int PTR_W = $clog2(RING_DEPTH),
    localparam int BIF_W = $clog2(BLOCK_LIMIT + 1)
) (
    input  logic [1:0]         action,
    input  logic               endpoint_idle,
    input  logic               endpoint_accepts,
    input  logic [9:0]         fetch_index,
    input  logic [PTR_W-1:0]   head,
    input  logic [PTR_W-1:0]   tail,
    input  logic [BIF_W-1:0]   bif,
    output logic [PTR_W-1:0]   head_next,
    output logic [PTR_W-1:0]   tail_next,
    output logic [BIF_W-1:0]   bif_next,
    output logic               mem_we,
    output utrbd_pkg::result_t res
);

    localparam int SW = ((PTR_W > BIF_W) ? PTR_W : BIF_W) + 1;
    localparam int RW = PTR_W + 1;

    logic [PTR_W-1:0] head_inc;
    logic             full;
    logic             bif_nz;
    logic             zlp;
    logic [SW-1:0]    ret_sum;
    logic [SW-1:0]    ret_wrap;
    logic [PTR_W-1:0] tail_ret;
    logic [RW-1:0]    run_raw;
    logic [RW-1:0]    run;

    always_comb
    begin
        head_inc = (RW'(head) == RW'(RING_DEPTH - 1)) ? '0 : head + PTR_W'(1);
        full     = (head_inc == tail);
        bif_nz   = (bif != '0);
        zlp      = bif_nz && ((17'(bif) & 17'(utrbd_pkg::USB_PACKET - 1)) == 17'd0);
        ret_sum  = SW'(tail) + SW'(bif);
        ret_wrap = (ret_sum >= SW'(RING_DEPTH)) ? ret_sum - SW'(RING_DEPTH) : ret_sum;
        tail_ret = bif_nz ? PTR_W'(ret_wrap) : tail;
        if (tail_ret > head)
            run_raw = RW'(RING_DEPTH) - RW'(tail_ret);
        else
            run_raw = RW'(head) - RW'(tail_ret);
        run = (17'(run_raw) > 17'(BLOCK_LIMIT)) ? RW'(BLOCK_LIMIT) : run_raw;
    end

    always_comb
    begin
        head_next = head;
        tail_next = tail;
        bif_next  = bif;
        mem_we    = 1'b0;
        res       = '0;
        unique case (action)
            utrbd_pkg::ACT_WRITE:
            begin
                if (!full)
                begin
                    mem_we             = 1'b1;
                    head_next          = head_inc;
                    res.write_accepted = 1'b1;
                end
            end
            utrbd_pkg::ACT_TICK:
            begin
                if (endpoint_idle)
                begin
                    tail_next = tail_ret;
                    bif_next  = '0;
                    if (zlp)
                    begin
                        res.send_valid       = 1'b1;
                        res.send_zero_length = 1'b1;
                        res.send_start       = 10'(tail_ret);
                    end
                    else if (tail_ret != head)
                    begin
                        res.send_valid  = 1'b1;
                        res.send_start  = 10'(tail_ret);
                        res.send_length = 7'(run);
                        if (endpoint_accepts)
                            bif_next = BIF_W'(run);
                    end
                end
            end
            utrbd_pkg::ACT_READ:
            begin
                res.read_en = (17'(fetch_index) < 17'(RING_DEPTH));
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

>>> sv/usb_tx_ring_block_drainer_core.sv
// Top level of the USB transmit ring block drainer: byte store, pointers, result pipeline.
// Depends on utrbd_pkg and utrbd_step.
//
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the action (write byte,
//   drain tick, read stored byte), s_tdata the byte, endpoint status and fetch
//   index. Each request yields exactly one result on the m_ channel.
//   Between the accepting edge and m_tvalid, one stage updates the pointers and
//   reads the byte store (registered read), and the next builds the result
//   word. One request is accepted every cycle while results are taken.
//   If the receiver holds m_tready low, results wait in the output register,
//   the middle stage fills, and s_tready drops until space opens again.
//   Reset clears the pointers, the block in flight and all valid flags; the byte
//   store keeps no reset value and must be written before it is read.
module usb_tx_ring_block_drainer_core #(
    parameter int RING_DEPTH  = utrbd_pkg::RING_DEPTH_DEF,
    parameter int BLOCK_LIMIT = utrbd_pkg::BLOCK_LIMIT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // data_byte[7:0], endpoint_idle[8], endpoint_accepts[9], fetch_index[19:10]
    input  logic [utrbd_pkg::IN_DATA_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [utrbd_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // write_accepted[0], free_count[10:1], send_valid[11], send_zero_length[12],
    // send_start[22:13], send_length[29:23], read_data[37:30]
    output logic [utrbd_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int BIF_W = $clog2(BLOCK_LIMIT + 1);
    localparam int RW    = PTR_W + 1;

    logic [7:0]         data_byte;
    logic               endpoint_idle;
    logic               endpoint_accepts;
    logic [9:0]         fetch_index;

    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   tail_reg;
    logic [BIF_W-1:0]   bif_reg;
    logic [PTR_W-1:0]   head_next;
    logic [PTR_W-1:0]   tail_next;
    logic [BIF_W-1:0]   bif_next;
    logic               mem_we;
    utrbd_pkg::result_t step_res;

    logic [7:0]         mem [RING_DEPTH];
    logic [7:0]         rd_data_reg;

    logic               s1_valid_reg;
    utrbd_pkg::result_t s1_res_reg;
    logic [PTR_W-1:0]   s1_head_reg;
    logic [PTR_W-1:0]   s1_tail_reg;

    logic                            out_valid_reg;
    logic [utrbd_pkg::OUT_DATA_W-1:0] out_tdata_reg;
    logic [utrbd_pkg::OUT_DATA_W-1:0] out_tdata_next;
    logic [RW-1:0]                   free_cnt;

    logic out_ready;
    logic s1_move;
    logic in_take;

    assign data_byte        = s_tdata[7:0];
    assign endpoint_idle    = s_tdata[8];
    assign endpoint_accepts = s_tdata[9];
    assign fetch_index      = s_tdata[19:10];

    assign out_ready = !out_valid_reg || m_tready;
    assign s1_move   = s1_valid_reg && out_ready;
    assign s_tready  = !s1_valid_reg || out_ready;
    assign in_take   = s_tvalid && s_tready;

    utrbd_step #(
        .RING_DEPTH  (RING_DEPTH),
        .BLOCK_LIMIT (BLOCK_LIMIT)
    ) u_step (
        .action           (s_tuser),
        .endpoint_idle    (endpoint_idle),
        .endpoint_accepts (endpoint_accepts),
        .fetch_index      (fetch_index),
        .head             (head_reg),
        .tail             (tail_reg),
        .bif              (bif_reg),
        .head_next        (head_next),
        .tail_next        (tail_next),
        .bif_next         (bif_next),
        .mem_we           (mem_we),
        .res              (step_res)
    );

    always_ff @(posedge clk)
    begin
        if (in_take && mem_we)
            mem[head_reg] <= data_byte;
        if (in_take && step_res.read_en)
            rd_data_reg <= mem[PTR_W'(fetch_index)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            bif_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                bif_reg      <= bif_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_res_reg  <= step_res;
            s1_head_reg <= head_next;
            s1_tail_reg <= tail_next;
        end
    end

    always_comb
    begin
        if (s1_tail_reg > s1_head_reg)
            free_cnt = RW'(s1_tail_reg) - RW'(s1_head_reg) - RW'(1);
        else
            free_cnt = RW'(s1_tail_reg) + RW'(RING_DEPTH) - RW'(s1_head_reg) - RW'(1);
        out_tdata_next        = '0;
        out_tdata_next[0]     = s1_res_reg.write_accepted;
        out_tdata_next[10:1]  = 10'(free_cnt);
        out_tdata_next[11]    = s1_res_reg.send_valid;
        out_tdata_next[12]    = s1_res_reg.send_zero_length;
        out_tdata_next[22:13] = s1_res_reg.send_start;
        out_tdata_next[29:23] = s1_res_reg.send_length;
        out_tdata_next[37:30] = s1_res_reg.read_en ? rd_data_reg : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
            out_tdata_reg <= out_tdata_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;

endmodule

>>> tb/tb_usb_tx_ring_block_drainer_core.sv
// Self-checking bench for usb_tx_ring_block_drainer_core: write, drain tick and read requests
// with random gaps and stalls, each result checked against an in-bench model of the ring.
// Depends on utrbd_pkg and the core RTL only.
module tb_usb_tx_ring_block_drainer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = utrbd_pkg::RING_DEPTH_DEF;
    localparam int MAX_BLOCK    = utrbd_pkg::BLOCK_LIMIT_DEF;
    localparam int RANDOM_ITEMS = 1250;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [9:0] fetch_index;
        logic       endpoint_accepts;
        logic       endpoint_idle;
        logic [7:0] data_byte;
    } ring_req_t;

    // packed lowest field last so the struct maps straight onto m_tdata[37:0]
    typedef struct packed {
        logic [7:0] read_data;
        logic [6:0] send_length;
        logic [9:0] send_start;
        logic       send_zero_length;
        logic       send_valid;
        logic [9:0] free_count;
        logic       write_accepted;
    } ring_rsp_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [utrbd_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [utrbd_pkg::IN_USER_W-1:0]  s_tuser = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [utrbd_pkg::OUT_DATA_W-1:0] m_tdata;

    usb_tx_ring_block_drainer_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ring model state
    logic [7:0] ring_bytes [DEPTH];
    bit         ever_written [DEPTH];
    int         written_idx [$];
    int         ring_head = 0;
    int         ring_tail = 0;
    int         in_flight = 0;

    ring_req_t  pending_req [$];
    ring_rsp_t  expected_rsp [$];

    ring_req_t  cur_req;
    int         send_gap = 0;
    bit         offering;
    int         recv_stall = 0;
    bit         no_idle = 1'b0;
    int         hold_requests = 0;
    int         hold_served = 0;
    int         hold_cnt = 0;

    int mismatches = 0;
    int n_checked = 0;
    int n_stored = 0;
    int n_refused = 0;
    int n_ticks = 0;
    int n_zlp = 0;
    int n_reads = 0;

    function automatic int ring_free();
        return (ring_tail + DEPTH - ring_head - 1) % DEPTH;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic ring_req_t make_req(input logic [1:0] act, input logic [7:0] d,
                                           input logic idle, input logic acc,
                                           input logic [9:0] idx);
        ring_req_t r;
        r.action           = act;
        r.data_byte        = d;
        r.endpoint_idle    = idle;
        r.endpoint_accepts = acc;
        r.fetch_index      = idx;
        return r;
    endfunction

    function automatic void tx_ring_predict(input ring_req_t r);
        ring_rsp_t e;
        int        run;
        bit        zlp_sent;
        e = '0;
        if (r.action == utrbd_pkg::ACT_WRITE)
        begin
            if (ring_free() != 0)
            begin
                ring_bytes[ring_head] = r.data_byte;
                if (!ever_written[ring_head])
                begin
                    ever_written[ring_head] = 1'b1;
                    written_idx.push_back(ring_head);
                end
                ring_head = (ring_head + 1) % DEPTH;
                e.write_accepted = 1'b1;
                n_stored++;
            end
            else
                n_refused++;
        end
        else if (r.action == utrbd_pkg::ACT_TICK)
        begin
            n_ticks++;
            if (r.endpoint_idle)
            begin
                zlp_sent = 1'b0;
                if (in_flight != 0)
                begin
                    ring_tail = (ring_tail + in_flight) % DEPTH;
                    if (in_flight % utrbd_pkg::USB_PACKET == 0)
                    begin
                        e.send_valid       = 1'b1;
                        e.send_zero_length = 1'b1;
                        e.send_start       = 10'(ring_tail);
                        zlp_sent           = 1'b1;
                        n_zlp++;
                    end
                    in_flight = 0;
                end
                if (!zlp_sent && ring_tail != ring_head)
                begin
                    run = (ring_tail > ring_head) ? DEPTH - ring_tail : ring_head - ring_tail;
                    if (run > MAX_BLOCK)
                        run = MAX_BLOCK;
                    e.send_valid  = 1'b1;
                    e.send_start  = 10'(ring_tail);
                    e.send_length = 7'(run);
                    if (r.endpoint_accepts)
                        in_flight = run;
                end
            end
        end
        else if (r.action == utrbd_pkg::ACT_READ)
        begin
            e.read_data = ring_bytes[r.fetch_index];
            n_reads++;
        end
        e.free_count = 10'(ring_free());
        expected_rsp.push_back(e);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      n_checked, name, got, want));
    endtask

    task automatic check_result(input logic [utrbd_pkg::OUT_DATA_W-1:0] word);
        ring_rsp_t got;
        ring_rsp_t want;
        got = ring_rsp_t'(word[$bits(ring_rsp_t)-1:0]);
        if (expected_rsp.size() == 0)
            report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                      n_checked));
        else
        begin
            want = expected_rsp.pop_front();
            compare_field("write_accepted", got.write_accepted, want.write_accepted);
            compare_field("free_count", got.free_count, want.free_count);
            compare_field("send_valid", got.send_valid, want.send_valid);
            compare_field("send_zero_length", got.send_zero_length, want.send_zero_length);
            compare_field("send_start", got.send_start, want.send_start);
            compare_field("send_length", got.send_length, want.send_length);
            compare_field("read_data", got.read_data, want.read_data);
        end
        n_checked++;
    endtask

    task automatic wait_for_drain();
        while (pending_req.size() != 0 || s_tvalid || expected_rsp.size() != 0)
            @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap = 0;
        end
        else
        begin
            offering = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                tx_ring_predict(cur_req);
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_req.size() != 0)
                begin
                    cur_req = pending_req.pop_front();
                    s_tdata <= {4'b0000, cur_req.fetch_index, cur_req.endpoint_accepts,
                                cur_req.endpoint_idle, cur_req.data_byte};
                    s_tuser <= cur_req.action;
                    send_gap = draw_gap();
                    offering = 1'b1;
                end
            end
            s_tvalid <= offering;
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_cnt <= HOLD_CYCLES;
        end
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_result(m_tdata);
                recv_stall = draw_gap();
            end
            else if (recv_stall > 0)
                recv_stall--;
            m_tready <= (recv_stall == 0) && (hold_cnt == 0);
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int         counted;
        int         n;
        int         sel;
        int         guard;
        bit         fill_done;
        bit         hold_done;
        logic       idle_b;
        logic [9:0] idx;

        counted   = 0;
        fill_done = 1'b0;
        hold_done = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty ring, busy endpoint, unused code, byte extremes, refused offer
        pending_req.push_back(make_req(utrbd_pkg::ACT_TICK, 8'h00, 1'b1, 1'b1, 10'h000));
        pending_req.push_back(make_req(utrbd_pkg::ACT_TICK, 8'hFF, 1'b0, 1'b1, 10'h3FF));
        pending_req.push_back(make_req(ACT_UNUSED, 8'hFF, 1'b1, 1'b1, 10'h3FF));
        pending_req.push_back(make_req(utrbd_pkg::ACT_WRITE, 8'h00, 1'b0, 1'b0, 10'h3FF));
        pending_req.push_back(make_req(utrbd_pkg::ACT_WRITE, 8'hFF, 1'b1, 1'b1, 10'h000));
        pending_req.push_back(make_req(utrbd_pkg::ACT_WRITE, 8'hA5, 1'b1, 1'b0, 10'h155));
        pending_req.push_back(make_req(utrbd_pkg::ACT_READ, 8'hFF, 1'b1, 1'b1, 10'h000));
        pending_req.push_back(make_req(utrbd_pkg::ACT_READ, 8'h00, 1'b0, 1'b0, 10'h001));
        pending_req.push_back(make_req(utrbd_pkg::ACT_READ, 8'h5A, 1'b1, 1'b0, 10'h002));
        pending_req.push_back(make_req(utrbd_pkg::ACT_TICK, 8'h00, 1'b1, 1'b0, 10'h000));
        pending_req.push_back(make_req(utrbd_pkg::ACT_TICK, 8'h00, 1'b1, 1'b1, 10'h000));
        pending_req.push_back(make_req(utrbd_pkg::ACT_TICK, 8'h00, 1'b0, 1'b1, 10'h000));
        pending_req.push_back(make_req(utrbd_pkg::ACT_WRITE, 8'h3C, 1'b0, 1'b1, 10'h2AA));
        pending_req.push_back(make_req(utrbd_pkg::ACT_TICK, 8'h00, 1'b1, 1'b1, 10'h000));
        pending_req.push_back(make_req(utrbd_pkg::ACT_TICK, 8'h00, 1'b1, 1'b1, 10'h000));
        pending_req.push_back(make_req(utrbd_pkg::ACT_TICK, 8'h00, 1'b1, 1'b0, 10'h000));

        while (counted < RANDOM_ITEMS)
        begin
            while (pending_req.size() > 4)
                @(negedge clk);
            no_idle = ($urandom_range(0, 7) == 0);
            if (!fill_done && counted >= 200)
            begin
                // fill to full with a few refused writes, then drain it completely
                wait_for_drain();
                n = ring_free() + 3;
                repeat (n)
                    pending_req.push_back(make_req(utrbd_pkg::ACT_WRITE, 8'($urandom),
                                                   1'($urandom), 1'($urandom),
                                                   10'($urandom)));
                counted += n;
                wait_for_drain();
                guard = 0;
                while ((ring_tail != ring_head || in_flight != 0) && guard < 200)
                begin
                    repeat (8)
                        pending_req.push_back(make_req(utrbd_pkg::ACT_TICK, 8'($urandom),
                                                       1'b1, 1'b1, 10'($urandom)));
                    counted += 8;
                    wait_for_drain();
                    guard++;
                end
                fill_done = 1'b1;
            end
            else if (!hold_done && counted >= 100)
            begin
                // receiver holds off while requests keep coming back to back
                wait_for_drain();
                hold_requests++;
                no_idle = 1'b1;
                repeat (40)
                begin
                    pending_req.push_back(make_req($urandom_range(0, 1) ? utrbd_pkg::ACT_WRITE
                                                                        : utrbd_pkg::ACT_TICK,
                                                   8'($urandom), 1'($urandom), 1'($urandom),
                                                   10'($urandom)));
                    counted++;
                end
                while (hold_cnt != 0)
                    @(negedge clk);
                wait_for_drain();
                hold_done = 1'b1;
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 35)
                begin
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 70)
                                                    : $urandom_range(1, 12);
                    repeat (n)
                        pending_req.push_back(make_req(utrbd_pkg::ACT_WRITE, 8'($urandom),
                                                       1'($urandom), 1'($urandom),
                                                       10'($urandom)));
                    counted += n;
                end
                else if (sel < 65)
                begin
                    n = $urandom_range(1, 12);
                    repeat (n)
                    begin
                        idle_b = ($urandom_range(0, 4) != 0);
                        pending_req.push_back(make_req(utrbd_pkg::ACT_TICK, 8'($urandom),
                                                       idle_b, ($urandom_range(0, 3) != 0),
                                                       10'($urandom)));
                    end
                    counted += n;
                end
                else if (sel < 80 && written_idx.size() != 0)
                begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                    begin
                        idx = 10'(written_idx[$urandom_range(0, written_idx.size() - 1)]);
                        pending_req.push_back(make_req(utrbd_pkg::ACT_READ, 8'($urandom),
                                                       1'($urandom), 1'($urandom), idx));
                    end
                    counted += n;
                end
                else if (sel < 97)
                begin
                    n = $urandom_range(0, 2);
                    if (n == 2 && written_idx.size() == 0)
                        n = 0;
                    idx = (n == 2) ? 10'(written_idx[$urandom_range(0, written_idx.size() - 1)])
                                   : 10'($urandom);
                    idle_b = 1'($urandom);
                    pending_req.push_back(make_req(2'(n), 8'($urandom), idle_b, 1'($urandom),
                                                   idx));
                    counted++;
                end
                else
                begin
                    pending_req.push_back(make_req($urandom_range(0, 1) ? ACT_UNUSED
                                                                        : utrbd_pkg::ACT_TICK,
                                                   8'($urandom), 1'b0, 1'($urandom),
                                                   10'($urandom)));
                    counted++;
                end
            end
        end

        wait_for_drain();
        repeat (8) @(negedge clk);
        $display("Checked %0d results: %0d bytes stored, %0d writes refused on a full ring,",
                 n_checked, n_stored, n_refused);
        $display("%0d drain ticks with %0d zero-length packets, %0d stored-byte reads.",
                 n_ticks, n_zlp, n_reads);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
